@@ rtl/stm_pkg.sv @@
// Shared types, constants and helpers for the sliding trimmed mean filter.
// No dependencies; every other file in rtl/ refers to this package by scope.
`default_nettype none

package stm_pkg;

    // Window geometry and sample format.
    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 16;

    // Largest usable trim count, so at least one sample is always kept.
    localparam int TRIM_MAX = (WINDOW - 1) / 2;

    // Fixed field widths of the ports.
    localparam int CFG_W      = 3;
    localparam int OUT_SUM_W  = 20;
    localparam int OUT_MEAN_W = 24;
    localparam int FRAC_BITS  = 8;

    // Internal widths derived from the window geometry.
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int RANK_W = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int KEEP_W = $clog2(WINDOW + 1);
    localparam int STEP_W = $clog2(NUM_W);

    // Saturation value of the trim register at the width of the port.
    localparam logic [CFG_W-1:0] TRIM_LIM =
        (TRIM_MAX > 7) ? {CFG_W{1'b1}} : CFG_W'(TRIM_MAX);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_FLUSH,
        S_START,
        S_DIV,
        S_PUT
    } t_state;

    // One ranked window entry, as seen by the accumulator.
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [RANK_W-1:0]             rank;
    } t_probe;

    // Divide request: magnitude of the unscaled sum, its sign and the kept count.
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [SUM_W-1:0]  mag;
        logic [KEEP_W-1:0] divisor;
    } t_div_req;

    // Divide response: done pulse, busy flag and signed quotient.
    typedef struct packed {
        logic              done;
        logic              busy;
        logic signed [NUM_W:0] quot;
    } t_div_rsp;

    // Number of set bits in a compare mask.
    function automatic logic [RANK_W-1:0] f_count(input logic [WINDOW-1:0] m);
        logic [RANK_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < WINDOW; i++) begin
            cnt = cnt + RANK_W'(m[i]);
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

@@ rtl/stm_window.sv @@
// Sample window held as a shift line, with a compare row that ranks one entry a cycle.
// Depends on stm_pkg for widths, the probe type and the mask count helper.
`default_nettype none

module stm_window (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_shift,
    input  wire logic signed [stm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                  i_probe,
    input  wire logic [stm_pkg::IDX_W-1:0]             i_index,
    output      stm_pkg::t_probe                       o_probe
);

    logic signed [stm_pkg::SAMPLE_BITS-1:0] r_taps [stm_pkg::WINDOW];
    logic signed [stm_pkg::SAMPLE_BITS-1:0] r_value;
    logic [stm_pkg::WINDOW-1:0]             r_mask;
    logic                                   r_valid;

    logic signed [stm_pkg::SAMPLE_BITS-1:0] w_key;
    logic [stm_pkg::WINDOW-1:0]             w_lower;

    // A new sample enters at the head and the oldest one falls off the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < stm_pkg::WINDOW; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_shift) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < stm_pkg::WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    // Compare row: an entry ranks below the key if it is smaller, or equal and
    // at a lower position, so that ties get distinct ranks.
    assign w_key = r_taps[i_index];

    always_comb begin
        for (int j = 0; j < stm_pkg::WINDOW; j++) begin
            w_lower[j] = (r_taps[j] < w_key) ||
                         ((r_taps[j] == w_key) && (j < int'(i_index)));
        end
    end

    // Register the compare result; the count is taken from the registered mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_probe) begin
            r_value <= w_key;
            r_mask  <= w_lower;
        end
    end

    assign o_probe.valid = r_valid;
    assign o_probe.value = r_value;
    assign o_probe.rank  = stm_pkg::f_count(r_mask);

endmodule

`default_nettype wire

@@ rtl/stm_div.sv @@
// Restoring divider, one quotient bit a cycle, for the scaled trimmed sum.
// Depends on stm_pkg for widths and the request and response types.
`default_nettype none

module stm_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stm_pkg::t_div_req i_req,
    output      stm_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic                             r_neg;
    logic [stm_pkg::STEP_W-1:0]       r_step;
    logic [stm_pkg::NUM_W-1:0]        r_quo;
    logic [stm_pkg::KEEP_W-1:0]       r_rem;
    logic [stm_pkg::KEEP_W-1:0]       r_div;

    logic [stm_pkg::KEEP_W:0]         w_trial;
    logic                             w_fit;
    logic [stm_pkg::KEEP_W-1:0]       w_rem;
    logic signed [stm_pkg::NUM_W:0]   w_mag;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign w_trial = {r_rem, r_quo[stm_pkg::NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});
    assign w_rem   = w_fit ? stm_pkg::KEEP_W'(w_trial - {1'b0, r_div})
                           : stm_pkg::KEEP_W'(w_trial);

    // Control: busy for one step per dividend bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= stm_pkg::STEP_W'(stm_pkg::NUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out at the top while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= {i_req.mag, {stm_pkg::FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_quo <= {r_quo[stm_pkg::NUM_W-2:0], w_fit};
            r_rem <= w_rem;
        end
    end

    // Restore the sign; the magnitude quotient already truncates toward zero.
    assign w_mag = $signed({1'b0, r_quo});

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_neg ? -w_mag : w_mag;

endmodule

`default_nettype wire

@@ rtl/sliding_trimmed_mean_filter_core.sv @@
// Sliding-window trimmed mean: each sample word replaces the oldest of 16 stored
// samples, and the block returns the window sum without the trim_count smallest
// and largest samples, plus that sum times 256 divided by the kept count,
// truncated toward zero. A compare row ranks one window entry per cycle, and a
// restoring divider then produces one quotient bit per cycle. o_ready is high
// only between words; a finished result waits in the output register while the
// next word is taken, and a result that is still waiting there when the next
// one is done holds the sequencer until it is taken. The trim register saturates
// at (WINDOW-1)/2 and takes writes only between words.
`default_nettype none

module sliding_trimmed_mean_filter_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration write channel.
    input  wire logic                                   i_cfg_valid,
    output      logic                                   o_cfg_ready,
    input  wire logic [stm_pkg::CFG_W-1:0]              i_cfg_data,
    // Sample input channel.
    input  wire logic                                   i_valid,
    output      logic                                   o_ready,
    input  wire logic signed [stm_pkg::SAMPLE_BITS-1:0] i_sample,
    // Result output channel.
    output      logic                                   o_valid,
    input  wire logic                                   i_ready,
    output      logic signed [stm_pkg::OUT_SUM_W-1:0]   o_trimmed_sum,
    output      logic signed [stm_pkg::OUT_MEAN_W-1:0]  o_mean_q8
);

    stm_pkg::t_state                     r_state;
    stm_pkg::t_state                     n_state;
    logic [stm_pkg::IDX_W-1:0]           r_index;
    logic [stm_pkg::IDX_W-1:0]           n_index;
    logic [stm_pkg::CFG_W-1:0]           r_trim;
    logic signed [stm_pkg::SUM_W-1:0]    r_acc;
    logic                                r_o_valid;
    logic signed [stm_pkg::OUT_SUM_W-1:0]  r_o_sum;
    logic signed [stm_pkg::OUT_MEAN_W-1:0] r_o_mean;

    logic                                w_accept;
    logic                                w_probe_en;
    logic                                w_load;
    logic                                w_keep;
    logic [stm_pkg::SUM_W-1:0]           w_mag;
    stm_pkg::t_probe                     w_probe;
    stm_pkg::t_div_req                   w_req;
    stm_pkg::t_div_rsp                   w_rsp;

    assign w_accept = i_valid && o_ready;

    // Trim register, saturated so the kept count never drops below one.
    // It is only written while no word is being ranked or divided.
    assign o_cfg_ready = (r_state == stm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_trim <= (int'(i_cfg_data) > stm_pkg::TRIM_MAX) ? stm_pkg::TRIM_LIM
                                                             : i_cfg_data;
        end
    end

    // Window storage and ranking.
    stm_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept),
        .i_sample (i_sample),
        .i_probe  (w_probe_en),
        .i_index  (r_index),
        .o_probe  (w_probe)
    );

    // An entry is summed when its rank lies inside the kept band.
    assign w_keep = (int'(w_probe.rank) >= int'(r_trim)) &&
                    (int'(w_probe.rank) <= stm_pkg::WINDOW - 1 - int'(r_trim));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc <= '0;
        end else if (w_probe.valid && w_keep) begin
            r_acc <= r_acc + stm_pkg::SUM_W'(w_probe.value);
        end
    end

    // Divide the magnitude of the sum, scaled inside the divider, by the kept count.
    assign w_mag = r_acc[stm_pkg::SUM_W-1] ? stm_pkg::SUM_W'(-r_acc)
                                           : stm_pkg::SUM_W'(r_acc);

    assign w_req.start   = (r_state == stm_pkg::S_START);
    assign w_req.neg     = r_acc[stm_pkg::SUM_W-1];
    assign w_req.mag     = w_mag;
    assign w_req.divisor = stm_pkg::KEEP_W'(stm_pkg::WINDOW - 2 * int'(r_trim));

    stm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stm_pkg::S_IDLE;
            r_index <= '0;
        end else begin
            r_state <= n_state;
            r_index <= n_index;
        end
    end

    // Next state and control outputs.
    always_comb begin
        n_state    = r_state;
        n_index    = r_index;
        o_ready    = 1'b0;
        w_probe_en = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            stm_pkg::S_IDLE: begin
                o_ready = 1'b1;
                n_index = '0;
                if (i_valid) begin
                    n_state = stm_pkg::S_RANK;
                end
            end
            stm_pkg::S_RANK: begin
                w_probe_en = 1'b1;
                n_index    = r_index + 1'b1;
                if (r_index == stm_pkg::IDX_W'(stm_pkg::WINDOW - 1)) begin
                    n_index = '0;
                    n_state = stm_pkg::S_FLUSH;
                end
            end
            stm_pkg::S_FLUSH: begin
                n_state = stm_pkg::S_START;
            end
            stm_pkg::S_START: begin
                n_state = stm_pkg::S_DIV;
            end
            stm_pkg::S_DIV: begin
                if (w_rsp.done) begin
                    n_state = stm_pkg::S_PUT;
                end
            end
            stm_pkg::S_PUT: begin
                if (!r_o_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = stm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stm_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_sum  <= stm_pkg::OUT_SUM_W'(r_acc);
            r_o_mean <= stm_pkg::OUT_MEAN_W'(w_rsp.quot);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_trimmed_sum = r_o_sum;
    assign o_mean_q8     = r_o_mean;

`ifndef SYNTHESIS
    // An accepted word always starts ranking at the first window entry.
    a_start_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == stm_pkg::S_RANK) && (r_index == '0))
        else $error("ranking did not start at entry zero");

    // The divider only finishes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == stm_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    // The divider is idle whenever a new word can be taken.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_rsp.busy)
        else $error("divider busy while accepting a word");

    // The trim register never exceeds its saturation value.
    a_trim_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trim <= stm_pkg::TRIM_LIM)
        else $error("trim count above its limit");

    // A waiting result is not overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stm_pkg::S_PUT) && r_o_valid && !i_ready
        |=> r_o_valid && $stable(r_o_sum) && $stable(r_o_mean))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for sliding_trimmed_mean_filter_core: directed table, then random words.
// Depends on rtl/stm_pkg.sv for widths and the trim limit, and on the core itself.
`timescale 1ns / 100ps

module tb_top;

    // Cycles with no accepted word on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Cycles allowed after the last result for any stray word to show up.
    localparam int TAIL_CYCLES = 100;
    localparam int N_DIR       = 28;
    localparam int N_PHASES    = 10;
    localparam int PHASE_WORDS = 145;

    // One expected result word.
    typedef struct packed {
        logic signed [stm_pkg::OUT_SUM_W-1:0]  sum;
        logic signed [stm_pkg::OUT_MEAN_W-1:0] mean;
    } t_filt_res;

    // Directed stimulus rows: either a trim register write or a sample word.
    typedef enum logic {ROW_TRIM, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic signed [31:0] value;
        logic               typed;
        logic signed [31:0] sum_v;
        logic signed [31:0] mean_v;
    } t_dir_row;

    // Hand-computed results only where they are obvious from a cleared window.
    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_TRIM,   0,      1'b0, 0,     0},
        '{ROW_SAMPLE, 32767,  1'b1, 32767, 524272},
        '{ROW_SAMPLE, -32768, 1'b1, -1,    -16},
        '{ROW_SAMPLE, 0,      1'b1, -1,    -16},
        '{ROW_SAMPLE, -1,     1'b1, -2,    -32},
        '{ROW_SAMPLE, 1,      1'b1, -1,    -16},
        '{ROW_SAMPLE, 21845,  1'b0, 0,     0},
        '{ROW_SAMPLE, -21846, 1'b0, 0,     0},
        '{ROW_SAMPLE, 255,    1'b0, 0,     0},
        '{ROW_SAMPLE, -256,   1'b0, 0,     0},
        '{ROW_SAMPLE, 7,      1'b0, 0,     0},
        '{ROW_SAMPLE, 7,      1'b0, 0,     0},
        '{ROW_SAMPLE, 7,      1'b0, 0,     0},
        '{ROW_SAMPLE, 7,      1'b0, 0,     0},
        '{ROW_SAMPLE, -3,     1'b0, 0,     0},
        '{ROW_SAMPLE, 12,     1'b0, 0,     0},
        '{ROW_SAMPLE, 32767,  1'b0, 0,     0},
        '{ROW_SAMPLE, -32768, 1'b0, 0,     0},
        '{ROW_TRIM,   7,      1'b0, 0,     0},
        '{ROW_SAMPLE, 7,      1'b0, 0,     0},
        '{ROW_SAMPLE, -7,     1'b0, 0,     0},
        '{ROW_SAMPLE, 32767,  1'b0, 0,     0},
        '{ROW_TRIM,   1,      1'b0, 0,     0},
        '{ROW_SAMPLE, 0,      1'b0, 0,     0},
        '{ROW_SAMPLE, -32768, 1'b0, 0,     0},
        '{ROW_TRIM,   3,      1'b0, 0,     0},
        '{ROW_SAMPLE, 100,    1'b0, 0,     0},
        '{ROW_SAMPLE, -100,   1'b0, 0,     0}
    };

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_cfg_valid = 1'b0;
    logic                                   o_cfg_ready;
    logic [stm_pkg::CFG_W-1:0]              i_cfg_data = '0;
    logic                                   i_valid = 1'b0;
    logic                                   o_ready;
    logic signed [stm_pkg::SAMPLE_BITS-1:0] i_sample = '0;
    logic                                   o_valid;
    logic                                   i_ready = 1'b0;
    logic signed [stm_pkg::OUT_SUM_W-1:0]   o_trimmed_sum;
    logic signed [stm_pkg::OUT_MEAN_W-1:0]  o_mean_q8;

    // Shadow of the filter state used for prediction.
    longint    win_hist [stm_pkg::WINDOW];
    int        next_slot;
    longint    win_total;
    int        trim_now;
    t_filt_res awaited_means [$];

    int mismatch_cnt;
    int quiet_cycles;
    bit no_gaps;

    sliding_trimmed_mean_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_trimmed_sum (o_trimmed_sum),
        .o_mean_q8     (o_mean_q8)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Push a sample into the shadow window and work out the trimmed sum and mean.
    function automatic t_filt_res next_trimmed_mean(
        input logic signed [stm_pkg::SAMPLE_BITS-1:0] smp
    );
        longint    ordered [stm_pkg::WINDOW];
        longint    key;
        longint    trimmed;
        longint    kept;
        longint    scaled;
        int        j;
        t_filt_res r;
        win_total = win_total - win_hist[next_slot] + longint'(smp);
        win_hist[next_slot] = smp;
        next_slot = (next_slot + 1) % stm_pkg::WINDOW;
        // Insertion sort of a copy of the window.
        for (int i = 0; i < stm_pkg::WINDOW; i++) begin
            ordered[i] = win_hist[i];
        end
        for (int i = 1; i < stm_pkg::WINDOW; i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        // Drop trim_now values from each end of the ordered window.
        trimmed = win_total;
        for (int k = 0; k < trim_now; k++) begin
            trimmed = trimmed - ordered[k] - ordered[stm_pkg::WINDOW - 1 - k];
        end
        kept = stm_pkg::WINDOW - 2 * trim_now;
        if (kept < 1) begin
            kept = 1;
        end
        // Signed division truncates toward zero.
        scaled = (trimmed * (longint'(1) << stm_pkg::FRAC_BITS)) / kept;
        r.sum  = trimmed[stm_pkg::OUT_SUM_W-1:0];
        r.mean = scaled[stm_pkg::OUT_MEAN_W-1:0];
        return r;
    endfunction

    // Present one sample word, with random gaps before it, and wait until it is taken.
    task automatic feed_sample(input logic signed [stm_pkg::SAMPLE_BITS-1:0] s);
        while (!no_gaps && $urandom_range(0, 99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic await_results();
        i_valid <= 1'b0;
        while (awaited_means.size() != 0) @(posedge i_clk);
    endtask

    // Trim writes happen only with the core drained.
    task automatic write_trim(input logic [stm_pkg::CFG_W-1:0] v);
        await_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        trim_now = (v > stm_pkg::TRIM_LIM) ? int'(stm_pkg::TRIM_LIM) : int'(v);
    endtask

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        if (mismatch_cnt < 10) begin
            $display("Mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        end
        mismatch_cnt++;
    endtask

    // Receiver side: random back-pressure, none during the calm stretch.
    always @(posedge i_clk) begin
        i_ready <= no_gaps || ($urandom_range(0, 99) >= 27);
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : check_out
        t_filt_res due;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_means.size() == 0) begin
                flag_mismatch("unexpected result word (trimmed_sum)", 0, o_trimmed_sum);
            end else begin
                due = awaited_means.pop_front();
                if (o_trimmed_sum !== due.sum) begin
                    flag_mismatch("trimmed_sum", due.sum, o_trimmed_sum);
                end
                if (o_mean_q8 !== due.mean) begin
                    flag_mismatch("mean_q8", due.mean, o_mean_q8);
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, directed table, then random phases with varied trim settings.
    initial begin
        t_dir_row                               row;
        t_filt_res                              due;
        logic signed [stm_pkg::SAMPLE_BITS-1:0] s;
        logic signed [stm_pkg::SAMPLE_BITS-1:0] run_val;
        int                                     run_left;
        int                                     pick;
        int                                     word_no;
        logic [stm_pkg::CFG_W-1:0]              trim_pick;

        run_left = 0;
        word_no  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int k = 0; k < N_DIR; k++) begin
            row = dir_rows[k];
            if (row.kind == ROW_TRIM) begin
                write_trim(row.value[stm_pkg::CFG_W-1:0]);
            end else begin
                feed_sample(row.value[stm_pkg::SAMPLE_BITS-1:0]);
                due = next_trimmed_mean(row.value[stm_pkg::SAMPLE_BITS-1:0]);
                if (row.typed) begin
                    due.sum  = row.sum_v[stm_pkg::OUT_SUM_W-1:0];
                    due.mean = row.mean_v[stm_pkg::OUT_MEAN_W-1:0];
                end
                awaited_means.push_back(due);
            end
        end

        // Random phases; the first two pin the trim extremes.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                trim_pick = '0;
            end else if (ph == 1) begin
                trim_pick = stm_pkg::TRIM_LIM;
            end else begin
                trim_pick = stm_pkg::CFG_W'($urandom_range(0, 7));
            end
            write_trim(trim_pick);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                no_gaps = (word_no >= 500 && word_no < 800);
                if (run_left != 0) begin
                    s = run_val;
                    run_left--;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        // Full-range sample.
                        s = stm_pkg::SAMPLE_BITS'($urandom);
                    end else if (pick < 60) begin
                        // Run of an input extreme, sometimes long enough to fill the window.
                        run_val  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        run_left = $urandom_range(4, 20);
                        s        = run_val;
                    end else if (pick < 75) begin
                        // Small values around zero, so ties are common.
                        s = stm_pkg::SAMPLE_BITS'($urandom_range(0, 8)) - 16'sd4;
                    end else if (pick < 85) begin
                        // Values at or just inside the extremes.
                        s = $urandom_range(0, 1)
                            ? 16'sh7FFF - stm_pkg::SAMPLE_BITS'($urandom_range(0, 3))
                            : 16'sh8000 + stm_pkg::SAMPLE_BITS'($urandom_range(0, 3));
                    end else begin
                        // Short run of one random value.
                        run_val  = stm_pkg::SAMPLE_BITS'($urandom);
                        run_left = $urandom_range(2, 9);
                        s        = run_val;
                    end
                end
                feed_sample(s);
                awaited_means.push_back(next_trimmed_mean(s));
                word_no++;
            end
        end
        no_gaps = 1'b0;

        // Drain and leave room for any stray result word.
        await_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && awaited_means.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
